@@ sv/whisk_pkg.sv @@
// shared types and constants for the tlv record parser
package whisk_pkg;

	// record type codes carried in the first byte of a record
	localparam logic [7:0] TYPE_TIME     = 8'h01;
	localparam logic [7:0] TYPE_POSITION = 8'h02;
	localparam logic [7:0] TYPE_ALTITUDE = 8'h03;

	// minimum data lengths for each known record type
	localparam logic [7:0] LEN_SHORT = 8'd4;
	localparam logic [7:0] LEN_LONG  = 8'd8;

	// result kind codes
	localparam logic [1:0] KIND_TIME     = 2'd0;
	localparam logic [1:0] KIND_POSITION = 2'd1;
	localparam logic [1:0] KIND_ALTITUDE = 2'd2;
	localparam logic [1:0] KIND_END      = 2'd3;

	// width of the packed result data word
	localparam int RES_DATA_W = 128;

	// parser phase, one-hot
	typedef enum logic [2:0] {
		PH_TYPE   = 3'b001,
		PH_LENGTH = 3'b010,
		PH_DATA   = 3'b100
	} phase_t;

	// one result item
	typedef struct packed {
		logic [1:0]         kind;
		logic [31:0]        time_value;
		logic signed [31:0] latitude;
		logic signed [31:0] longitude;
		logic signed [31:0] altitude;
		logic               done;
	} whisk_res_t;

endpackage

@@ sv/whisker_tlv_parser.sv @@
// top level of the streaming tlv record parser
//
// Input stream: one payload byte per request on s_tdata[7:0], s_tlast on the
// final byte of a payload. Records are a type byte, a length byte and that
// many data bytes. Output stream: one request per completed timestamp,
// position or altitude record that meets its minimum length, and an end
// marker (kind 3) on the final byte if that byte did not itself complete
// such a record; m_tlast marks the request that closes the payload.
// Latency: a result appears on the cycle after the byte that completes it.
// Throughput: one byte per cycle; the parser state and the single result
// register both update each cycle, so s_tready stays high unless a result
// is held in the output register and m_tready is low.
// Reset: clears the parser to expect a type byte and empties the output.
// Receiver stall: the held result stays put and s_tready drops until it is
// taken; a byte that yields no result also waits, since s_tready is shared.
module whisker_tlv_parser import whisk_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,  // data_byte[7:0]
	input  logic                  s_tlast,  // last_byte
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [RES_DATA_W-1:0] m_tdata,  // time_value, latitude, longitude, altitude
	output logic [1:0]            m_tuser,  // record_kind[1:0]
	output logic                  m_tlast   // payload_done
);

	logic       step;
	logic       emit;
	logic       room;
	whisk_res_t res;
	whisk_res_t held;

	// input request handshake
	assign s_tready = room;
	assign step     = s_tvalid && room;

	// per-byte record parser
	whisk_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (s_tdata),
		.last_byte (s_tlast),
		.res       (res),
		.emit      (emit)
	);

	// output result register
	whisk_out u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (step && emit),
		.res    (res),
		.take   (m_tready),
		.room   (room),
		.valid  (m_tvalid),
		.held   (held)
	);

	// output packing
	assign m_tdata = {held.altitude, held.longitude, held.latitude, held.time_value};
	assign m_tuser = held.kind;
	assign m_tlast = held.done;

	// the final byte of a payload always yields a closing result
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> m_tvalid && m_tlast)
		else $error("final byte did not produce a closing result");

	// an end marker only appears on the closing result
	a_end_marker: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_END |-> m_tlast)
		else $error("end marker without payload end");

	// no byte is taken while a result is stalled
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while output stalled");

	// timestamp field is zero unless the result is a timestamp
	a_time_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != KIND_TIME |-> m_tdata[31:0] == 32'd0)
		else $error("stray timestamp value");

endmodule

@@ sv/whisk_parse.sv @@
// record state tracking and result decode for one payload byte
module whisk_parse import whisk_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output whisk_res_t res,
	output logic       emit
);

	phase_t      phase_q, phase_n;
	logic [7:0]  type_q, type_n;
	logic [7:0]  len_q, len_n;
	logic [7:0]  seen_q, seen_n;
	logic [63:0] val_q, val_n;
	logic        complete;
	logic        hit;

	// next record state from the current byte
	always_comb begin
		phase_n  = phase_q;
		type_n   = type_q;
		len_n    = len_q;
		seen_n   = seen_q;
		val_n    = val_q;
		complete = 1'b0;
		unique case (phase_q)
			PH_LENGTH: begin
				len_n  = data_byte;
				seen_n = '0;
				val_n  = '0;
				if (data_byte == 8'd0) begin
					complete = 1'b1;
					phase_n  = PH_TYPE;
				end else begin
					phase_n = PH_DATA;
				end
			end
			PH_DATA: begin
				if (seen_q < LEN_LONG) begin
					val_n = val_q | ({56'd0, data_byte} << {seen_q[2:0], 3'b000});
				end
				seen_n = seen_q + 8'd1;
				if (seen_n >= len_q) begin
					complete = 1'b1;
					phase_n  = PH_TYPE;
				end
			end
			default: begin
				type_n  = data_byte;
				phase_n = PH_LENGTH;
			end
		endcase
	end

	// result decode for a completed record and payload end
	always_comb begin
		res = '0;
		hit = 1'b0;
		if (complete) begin
			if (type_n == TYPE_TIME && len_n >= LEN_SHORT) begin
				hit            = 1'b1;
				res.kind       = KIND_TIME;
				res.time_value = val_n[31:0];
			end else if (type_n == TYPE_POSITION && len_n >= LEN_LONG) begin
				hit           = 1'b1;
				res.kind      = KIND_POSITION;
				res.latitude  = val_n[31:0];
				res.longitude = val_n[63:32];
			end else if (type_n == TYPE_ALTITUDE && len_n >= LEN_SHORT) begin
				hit          = 1'b1;
				res.kind     = KIND_ALTITUDE;
				res.altitude = val_n[31:0];
			end
		end
		emit = hit;
		if (last_byte) begin
			if (!hit) begin
				res      = '0;
				res.kind = KIND_END;
			end
			res.done = 1'b1;
			emit     = 1'b1;
		end
	end

	// state registers, cleared at payload end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TYPE;
			type_q  <= '0;
			len_q   <= '0;
			seen_q  <= '0;
			val_q   <= '0;
		end else if (step) begin
			if (last_byte) begin
				phase_q <= PH_TYPE;
				type_q  <= '0;
				len_q   <= '0;
				seen_q  <= '0;
				val_q   <= '0;
			end else begin
				phase_q <= phase_n;
				type_q  <= type_n;
				len_q   <= len_n;
				seen_q  <= seen_n;
				val_q   <= val_n;
			end
		end
	end

endmodule

@@ sv/whisk_out.sv @@
// result register between the parser and the output stream
module whisk_out import whisk_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  whisk_res_t res,
	input  logic       take,
	output logic       room,
	output logic       valid,
	output whisk_res_t held
);

	logic       valid_q;
	whisk_res_t res_q;

	// a new result may enter when the register is empty or drains now
	assign room  = !valid_q || take;
	assign valid = valid_q;
	assign held  = res_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (room) begin
			valid_q <= load;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (room && load) begin
			res_q <= res;
		end
	end

endmodule

@@ test/whisker_tlv_parser_tb.sv @@
// self-checking testbench for the streaming tlv record parser
`timescale 1ns / 100ps

module whisker_tlv_parser_tb import whisk_pkg::*;;

	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_TARGET = 550;

	// one byte of stimulus, with a typed-in result where it is obvious
	typedef struct {
		logic [7:0] data;
		logic       last;
		bit         typed;
		whisk_res_t want;
	} byte_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata = 8'h00;
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [RES_DATA_W-1:0] m_tdata;
	logic [1:0]            m_tuser;
	logic                  m_tlast;

	byte_row_t  payload_bytes[$];
	whisk_res_t expected_records[$];
	int         mismatches = 0;
	int         idle_cycles = 0;
	bit         calm_send = 1'b0;
	bit         calm_take = 1'b0;

	// parser shadow state
	phase_t      sh_phase = PH_TYPE;
	logic [7:0]  sh_type = '0;
	logic [7:0]  sh_len = '0;
	logic [7:0]  sh_seen = '0;
	logic [63:0] sh_shift = '0;

	whisker_tlv_parser u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("tb: mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	function automatic whisk_res_t make_record(input logic [1:0] kind, input logic [31:0] tv,
			input logic [31:0] lat, input logic [31:0] lon, input logic [31:0] alt,
			input logic done);
		whisk_res_t r;
		r.kind = kind;
		r.time_value = tv;
		r.latitude = lat;
		r.longitude = lon;
		r.altitude = alt;
		r.done = done;
		return r;
	endfunction

	task automatic add_byte(input logic [7:0] d, input logic l);
		byte_row_t row;
		row.data = d;
		row.last = l;
		row.typed = 1'b0;
		row.want = '0;
		payload_bytes.push_back(row);
	endtask

	task automatic add_byte_typed(input logic [7:0] d, input logic l, input whisk_res_t want);
		byte_row_t row;
		row.data = d;
		row.last = l;
		row.typed = 1'b1;
		row.want = want;
		payload_bytes.push_back(row);
	endtask

	// advance the shadow parser by one byte
	task automatic parse_byte(input logic [7:0] b, input logic last,
			output logic hit, output whisk_res_t r);
		logic complete;
		complete = 1'b0;
		hit = 1'b0;
		r = '0;
		case (sh_phase)
			PH_LENGTH: begin
				sh_len = b;
				sh_seen = '0;
				sh_shift = '0;
				if (b == 8'd0) begin
					complete = 1'b1;
					sh_phase = PH_TYPE;
				end else begin
					sh_phase = PH_DATA;
				end
			end
			PH_DATA: begin
				if (sh_seen < 8'd8)
					sh_shift[8*sh_seen +: 8] = b;
				sh_seen = sh_seen + 8'd1;
				if (sh_seen >= sh_len) begin
					complete = 1'b1;
					sh_phase = PH_TYPE;
				end
			end
			default: begin
				sh_type = b;
				sh_phase = PH_LENGTH;
			end
		endcase
		// decide whether the finished record is usable
		if (complete) begin
			if (sh_type == TYPE_TIME && sh_len >= LEN_SHORT) begin
				r.kind = KIND_TIME;
				r.time_value = sh_shift[31:0];
				hit = 1'b1;
			end else if (sh_type == TYPE_POSITION && sh_len >= LEN_LONG) begin
				r.kind = KIND_POSITION;
				r.latitude = sh_shift[31:0];
				r.longitude = sh_shift[63:32];
				hit = 1'b1;
			end else if (sh_type == TYPE_ALTITUDE && sh_len >= LEN_SHORT) begin
				r.kind = KIND_ALTITUDE;
				r.altitude = sh_shift[31:0];
				hit = 1'b1;
			end
		end
		// final byte closes the payload and clears everything
		if (last) begin
			if (!hit) begin
				r = '0;
				r.kind = KIND_END;
			end
			r.done = 1'b1;
			hit = 1'b1;
			sh_phase = PH_TYPE;
			sh_type = '0;
			sh_len = '0;
			sh_seen = '0;
			sh_shift = '0;
		end
	endtask

	// hand-picked payloads covering value extremes and corners of the framing
	task automatic build_directed();
		// lone final byte right after reset: end marker only
		add_byte_typed(8'h00, 1'b1, make_record(KIND_END, '0, '0, '0, '0, 1'b1));
		// timestamp at its maximum
		add_byte(TYPE_TIME, 1'b0);
		add_byte(8'd4, 1'b0);
		add_byte(8'hff, 1'b0);
		add_byte(8'hff, 1'b0);
		add_byte(8'hff, 1'b0);
		add_byte_typed(8'hff, 1'b0, make_record(KIND_TIME, 32'hffff_ffff, '0, '0, '0, 1'b0));
		// position with most negative latitude and most positive longitude
		add_byte(TYPE_POSITION, 1'b0);
		add_byte(8'd8, 1'b0);
		add_byte(8'h00, 1'b0);
		add_byte(8'h00, 1'b0);
		add_byte(8'h00, 1'b0);
		add_byte(8'h80, 1'b0);
		add_byte(8'hff, 1'b0);
		add_byte(8'hff, 1'b0);
		add_byte(8'hff, 1'b0);
		add_byte_typed(8'h7f, 1'b0,
			make_record(KIND_POSITION, '0, 32'h8000_0000, 32'h7fff_ffff, '0, 1'b0));
		// zero length record of an unknown type
		add_byte(8'h07, 1'b0);
		add_byte(8'h00, 1'b0);
		// unknown type with one data byte
		add_byte(8'hfe, 1'b0);
		add_byte(8'h01, 1'b0);
		add_byte(8'h55, 1'b0);
		// altitude with one extra data byte that also ends the payload
		add_byte(TYPE_ALTITUDE, 1'b0);
		add_byte(8'd5, 1'b0);
		add_byte(8'h01, 1'b0);
		add_byte(8'h02, 1'b0);
		add_byte(8'h03, 1'b0);
		add_byte(8'h84, 1'b0);
		add_byte(8'haa, 1'b1);
		// lone type byte on the final byte is dropped
		add_byte_typed(TYPE_TIME, 1'b1, make_record(KIND_END, '0, '0, '0, '0, 1'b1));
	endtask

	// random payloads: mostly well-formed records, some stray bytes and cut-off tails
	task automatic build_random(input int target);
		logic [7:0] pl[$];
		int nrec;
		int sel;
		int need;
		int len;
		int part;
		logic [7:0] rtype;
		while (payload_bytes.size() < target) begin
			pl.delete();
			nrec = $urandom_range(1, 4);
			for (int i = 0; i < nrec; i++) begin
				if ($urandom_range(0, 15) == 0) begin
					pl.push_back(8'($urandom_range(0, 255)));
				end else begin
					sel = $urandom_range(0, 7);
					if (sel < 2)
						rtype = TYPE_TIME;
					else if (sel < 4)
						rtype = TYPE_POSITION;
					else if (sel < 6)
						rtype = TYPE_ALTITUDE;
					else
						rtype = 8'($urandom_range(0, 255));
					need = (rtype == TYPE_POSITION) ? 8 : 4;
					sel = $urandom_range(0, 19);
					if (sel == 0)
						len = 0;
					else if (sel == 1)
						len = $urandom_range(9, 40);
					else if (sel == 2)
						len = ($urandom_range(0, 15) == 0) ? 255 : $urandom_range(0, 3);
					else if (sel < 6)
						len = $urandom_range(1, need - 1);
					else
						len = need + $urandom_range(0, 2);
					pl.push_back(rtype);
					pl.push_back(8'(len));
					for (int j = 0; j < len; j++)
						pl.push_back(8'($urandom_range(0, 255)));
				end
			end
			// sometimes the payload ends inside a record
			if ($urandom_range(0, 5) == 0) begin
				pl.push_back(8'($urandom_range(1, 3)));
				if ($urandom_range(0, 1) == 1) begin
					len = $urandom_range(2, 9);
					pl.push_back(8'(len));
					part = $urandom_range(0, len - 2);
					for (int j = 0; j < part; j++)
						pl.push_back(8'($urandom_range(0, 255)));
				end
			end
			foreach (pl[j])
				add_byte(pl[j], j == pl.size() - 1);
		end
	endtask

	// stall watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// result side: random stalls, compare each request with the oldest expectation
	initial begin
		whisk_res_t got;
		whisk_res_t want;
		int gap;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 19) == 0)
				calm_take = !calm_take;
			gap = calm_take ? 0 : $urandom_range(0, 5);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			got.kind = m_tuser;
			got.time_value = m_tdata[31:0];
			got.latitude = m_tdata[63:32];
			got.longitude = m_tdata[95:64];
			got.altitude = m_tdata[127:96];
			got.done = m_tlast;
			if (expected_records.size() == 0) begin
				report_mismatch($sformatf("unexpected record kind %0d", got.kind));
			end else begin
				want = expected_records.pop_front();
				check_field("kind", {30'd0, got.kind}, {30'd0, want.kind});
				check_field("time_value", got.time_value, want.time_value);
				check_field("latitude", got.latitude, want.latitude);
				check_field("longitude", got.longitude, want.longitude);
				check_field("altitude", got.altitude, want.altitude);
				check_field("payload_done", {31'd0, got.done}, {31'd0, want.done});
			end
			@(negedge clk);
		end
	end

	// byte side: reset, then walk the directed table and the random payloads
	initial begin
		byte_row_t row;
		whisk_res_t res;
		logic hit;
		int gap;
		build_directed();
		build_random(RANDOM_TARGET);
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (int n = 0; n < payload_bytes.size(); n++) begin
			row = payload_bytes[n];
			if ($urandom_range(0, 19) == 0)
				calm_send = !calm_send;
			gap = calm_send ? 0 : $urandom_range(0, 5);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata <= row.data;
			s_tlast <= row.last;
			@(posedge clk);
			while (!s_tready)
				@(posedge clk);
			parse_byte(row.data, row.last, hit, res);
			if (row.typed)
				expected_records.push_back(row.want);
			else if (hit)
				expected_records.push_back(res);
			@(negedge clk);
		end
		s_tvalid <= 1'b0;
		// drain, then give the output register time to show any extra request
		while (expected_records.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
